>>> src/naca_pkg.sv
// ----------------------------------------------------------------------------
// naca_pkg: shared constants for the four-digit airfoil point pipeline
// Thickness polynomial coefficients, CORDIC gain, output limits and
// configuration register indexes.
// ----------------------------------------------------------------------------
package naca_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 17;
  localparam int OUT_W  = 18;

  // half-thickness polynomial, scaled by 10000 (magnitudes, signs in the sum)
  localparam int C_SQ   = 2969;
  localparam int C_X1   = 1260;
  localparam int C_X2   = 3516;
  localparam int C_X3   = 2843;
  localparam int C_X4   = 1036;

  // yt = round(t * poly / YT_DEN)
  localparam int YT_DEN  = 200000;
  localparam int YT_HALF = 100000;

  // YT_DEN = 64 * 3125: shift out the 64, then multiply by ceil(2^40 / 3125)
  localparam int YT_SHIFT  = 6;
  localparam int YT_RECIP  = 351843721;
  localparam int YT_RSHIFT = 40;

  // inverse CORDIC gain in Q30
  localparam longint INVK_Q30 = 64'd652032874;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  localparam int DIGIT_MAX = 9;
  localparam int THICK_MAX = 40;

  typedef enum logic [1:0] {
    CFG_MAX_CAMBER = 2'd0,
    CFG_CAMBER_POS = 2'd1,
    CFG_THICKNESS  = 2'd2
  } cfg_idx_t;

endpackage

>>> src/naca_four_digit_airfoil_point.sv
// ----------------------------------------------------------------------------
// naca_four_digit_airfoil_point: NACA four-digit surface point pipeline
//
//   channel  dir  fields (low bit first)
//   s_axis   in   x_pos[16:0]
//   m_axis   out  upper_x, upper_y, lower_x, lower_y, camber_height (18 b each)
//   cfg      in   0 max_camber, 1 camber_position, 2 thickness_percent
//
// One item per cycle while the pipe is not stalled. An accepted item passes
// through the pipeline stages to the result register: the slope divider
// (NSW = FRAC_BITS + 10 stages) sets the depth, the thickness path is padded
// to match. From the result register it enters the output queue, which
// drives m_tvalid.
// rst clears the valid bits and the queue and restores the digits. A two-entry
// output queue keeps accepting while a result waits; the pipe stalls only when
// the queue is full and a result sits at its end.
// ----------------------------------------------------------------------------
module naca_four_digit_airfoil_point #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // x_pos[16:0], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // upper_x, upper_y, lower_x, lower_y, camber_height, pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata
);
  import naca_pkg::*;

  localparam int FB   = FRAC_BITS;
  localparam int CS   = CORDIC_STAGES;
  localparam int XW   = IN_W;
  localparam longint ONE = longint'(1) << FB;
  localparam int RW   = (XW + FB + 1) / 2;
  localparam int MW   = (RW > XW) ? RW : XW;
  localparam int TW   = MW + 12;
  localparam int PW   = MW + 16;
  localparam int TPW  = PW + 7;
  localparam int YNW  = 28;
  localparam int YPW  = YNW + 30;
  localparam int SW   = FB + 11;
  localparam int SNW  = FB + 7;
  localparam int NCW  = FB + 14;
  localparam int NSW  = FB + 10;
  localparam int YQW  = FB + 2;
  localparam int CW   = FB + 5;
  localparam int KW   = YQW + FB + 1;
  localparam int SUMW = ((CW > XW) ? CW : XW + 1) + 1;
  localparam int PDW  = 5 * OUT_W;
  localparam int T0   = 1 + RW;
  localparam int TY   = T0 + 7;
  localparam int TC   = 6 + NSW;
  localparam int LAT  = TC + CS + 1;
  localparam longint INVK = (FB < 30) ?
      ((INVK_Q30 + (longint'(1) << (29 - FB))) >> (30 - FB)) : INVK_Q30;

  // configuration
  logic [3:0] max_camber;
  logic [3:0] camber_position;
  logic [5:0] thickness_percent;
  logic [3:0] m_c;
  logic [3:0] p_c;
  logic [5:0] t_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_camber        <= 4'd2;
      camber_position   <= 4'd4;
      thickness_percent <= 6'd13;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_CAMBER: max_camber        <= cfg_wdata[3:0];
        CFG_CAMBER_POS: camber_position   <= cfg_wdata[3:0];
        CFG_THICKNESS:  thickness_percent <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign m_c = (max_camber > 4'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : max_camber;
  assign p_c = (camber_position > 4'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : camber_position;
  assign t_c = (thickness_percent > 6'(THICK_MAX)) ? 6'(THICK_MAX) : thickness_percent;

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld;
  logic [1:0]     cnt;

  assign adv      = !vld[LAT-1] || (cnt != 2'd2);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage A: clamp x
  logic [XW-1:0] xin;
  logic [XW-1:0] xa;
  assign xin = s_tdata[XW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      xa <= (longint'(xin) > ONE) ? XW'(ONE) : xin;
    end
  end

  // stages B, C: powers of x, rounded
  logic [2*XW-1:0] p2;
  logic [2*XW-1:0] p3;
  logic [2*XW-1:0] p4;
  logic [XW-1:0]   xb;
  logic [XW-1:0]   x2;
  logic [XW-1:0]   x3;
  logic [XW-1:0]   x4;
  localparam logic [2*XW-1:0] RHALF = (2*XW)'(longint'(1) << (FB - 1));

  assign p2 = (2*XW)'(xa) * (2*XW)'(xa);
  assign p3 = (2*XW)'(x2) * (2*XW)'(xb);
  assign p4 = (2*XW)'(x2) * (2*XW)'(x2);

  always_ff @(posedge clk) begin
    if (adv) begin
      xb <= xa;
      x2 <= XW'((p2 + RHALF) >> FB);
      x3 <= XW'((p3 + RHALF) >> FB);
      x4 <= XW'((p4 + RHALF) >> FB);
    end
  end

  // square root and aligned powers
  logic [RW-1:0]   sq;
  logic [XW-1:0]   xd;
  logic [XW-1:0]   x2d;
  logic [2*XW-1:0] x34d;

  naca_sqrt #(.XW(XW), .FB(FB)) u_sqrt (
    .clk(clk), .en(adv), .x(xa), .root(sq)
  );

  naca_dly #(.W(XW), .D(RW)) u_dly_x (
    .clk(clk), .en(adv), .din(xa), .dout(xd)
  );
  naca_dly #(.W(XW), .D(RW - 1)) u_dly_x2 (
    .clk(clk), .en(adv), .din(x2), .dout(x2d)
  );
  naca_dly #(.W(2 * XW), .D(RW - 2)) u_dly_x34 (
    .clk(clk), .en(adv), .din({x4, x3}), .dout(x34d)
  );

  // thickness polynomial
  logic [TW-1:0]        t_sq;
  logic [TW-1:0]        t_x1;
  logic [TW-1:0]        t_x2;
  logic [TW-1:0]        t_x3;
  logic [TW-1:0]        t_x4;
  logic signed [PW-1:0] poly;
  logic signed [TPW-1:0] tp;
  logic [TPW-1:0]       tp_mag;
  logic [YNW-1:0]       yt_num;
  logic                 yt_sgn;

  assign tp_mag = tp[TPW-1] ? TPW'(-tp) : TPW'(tp);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_sq   <= TW'(sq) * TW'(C_SQ);
      t_x1   <= TW'(xd) * TW'(C_X1);
      t_x2   <= TW'(x2d) * TW'(C_X2);
      t_x3   <= TW'(x34d[XW-1:0]) * TW'(C_X3);
      t_x4   <= TW'(x34d[2*XW-1:XW]) * TW'(C_X4);
      poly   <= PW'(t_sq) - PW'(t_x1) - PW'(t_x2) + PW'(t_x3) - PW'(t_x4);
      tp     <= TPW'($signed({1'b0, t_c})) * TPW'(poly);
      yt_num <= YNW'(((TPW+1)'(tp_mag) + (TPW+1)'(YT_HALF)) >> YT_SHIFT);
      yt_sgn <= tp[TPW-1];
    end
  end

  // divide by the constant thickness denominator with a reciprocal multiply
  logic [YPW-1:0] yt_prod;
  logic [YQW-1:0] yt_q;
  logic           yt_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      yt_prod <= YPW'(yt_num) * YPW'(YT_RECIP);
      yt_neg  <= yt_sgn;
    end
  end

  assign yt_q = yt_prod[YT_RSHIFT +: YQW];

  // remove the CORDIC gain in advance
  logic [KW-1:0]        kprod;
  logic                 kneg;
  logic [KW-1:0]        kround;
  logic signed [CW-1:0] ytk;
  logic signed [CW-1:0] ytk_d;
  localparam logic [KW-1:0] KHALF = KW'(longint'(1) << (FB - 1));

  assign kround = (kprod + KHALF) >> FB;

  always_ff @(posedge clk) begin
    if (adv) begin
      kprod <= KW'(yt_q) * KW'(INVK);
      kneg  <= yt_neg;
      ytk   <= kneg ? -CW'(kround) : CW'(kround);
    end
  end

  naca_dly #(.W(CW), .D(TC - TY)) u_dly_ytk (
    .clk(clk), .en(adv), .din(ytk), .dout(ytk_d)
  );

  // camber line numerators and divisors
  logic                  fore;
  logic [6:0]            den0;
  longint                term;
  logic signed [SW-1:0]  cs;
  logic signed [SNW-1:0] csn;
  logic [6:0]            cden;
  logic signed [NCW:0]   ns;
  logic signed [NSW:0]   nsl;
  logic [6:0]            cden2;
  logic [NCW-1:0]        yc_num;
  logic                  yc_sgn;
  logic [13:0]           yc_den;
  logic [NSW-1:0]        sl_num;
  logic                  sl_sgn;
  logic [9:0]            sl_den;
  logic [NCW:0]          ns_mag;
  logic [NSW:0]          nsl_mag;

  assign fore = (p_c != 4'd0) && (longint'(xb) * 10 <= longint'(p_c) * ONE);
  assign den0 = fore ? 7'(p_c * p_c) : 7'((4'd10 - p_c) * (4'd10 - p_c));
  assign term = 20 * longint'(p_c) * longint'(xb) - 100 * longint'(x2);
  assign ns_mag  = ns[NCW] ? (NCW+1)'(-ns) : (NCW+1)'(ns);
  assign nsl_mag = nsl[NSW] ? (NSW+1)'(-nsl) : (NSW+1)'(nsl);

  always_ff @(posedge clk) begin
    if (adv) begin
      cs     <= fore ? SW'(term) : SW'((100 - 20 * longint'(p_c)) * ONE + term);
      csn    <= SNW'(2 * longint'(p_c) * ONE - 20 * longint'(xb));
      cden   <= den0;
      ns     <= (NCW+1)'($signed({1'b0, m_c})) * (NCW+1)'(cs);
      nsl    <= (NSW+1)'($signed({1'b0, m_c})) * (NSW+1)'(csn);
      cden2  <= cden;
      yc_num <= NCW'(ns_mag) + NCW'(cden2 * 7'd50);
      yc_sgn <= ns[NCW];
      yc_den <= 14'(cden2) * 14'd100;
      sl_num <= NSW'(nsl_mag) + NSW'(cden2 * 7'd5);
      sl_sgn <= nsl[NSW];
      sl_den <= 10'(cden2) * 10'd10;
    end
  end

  logic [NCW-1:0] yc_q;
  logic           yc_neg;
  logic [NSW-1:0] sl_q;
  logic           sl_neg;

  naca_div #(.NW(NCW), .DW(14)) u_div_yc (
    .clk(clk), .en(adv), .num(yc_num), .den(yc_den), .neg_in(yc_sgn),
    .quo(yc_q), .neg_out(yc_neg)
  );
  naca_div #(.NW(NSW), .DW(10)) u_div_sl (
    .clk(clk), .en(adv), .num(sl_num), .den(sl_den), .neg_in(sl_sgn),
    .quo(sl_q), .neg_out(sl_neg)
  );

  logic signed [CW-1:0] yc_s;
  logic signed [CW-1:0] sl_s;
  logic signed [CW-1:0] yc_d;
  logic signed [CW-1:0] sl_d;
  logic [XW-1:0]        x_out;

  assign yc_s = yc_neg ? -CW'(yc_q[YQW-1:0]) : CW'(yc_q[YQW-1:0]);
  assign sl_s = sl_neg ? -CW'(sl_q[YQW-1:0]) : CW'(sl_q[YQW-1:0]);

  naca_dly #(.W(CW), .D(TC - 5 - NSW)) u_dly_sl (
    .clk(clk), .en(adv), .din(sl_s), .dout(sl_d)
  );
  naca_dly #(.W(CW), .D(TC + CS - 5 - NCW)) u_dly_yc (
    .clk(clk), .en(adv), .din(yc_s), .dout(yc_d)
  );
  naca_dly #(.W(XW), .D(TC + CS - T0)) u_dly_xo (
    .clk(clk), .en(adv), .din(xd), .dout(x_out)
  );

  // place the thickness perpendicular to the camber line
  logic signed [CW-1:0] rx_c;
  logic signed [CW-1:0] ry_c;

  naca_cordic #(.CW(CW), .FB(FB), .CS(CS)) u_cordic (
    .clk(clk), .en(adv), .slope(sl_d), .ytk(ytk_d), .rx(rx_c), .ry(ry_c)
  );

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUMW-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > SUMW'(OUT_MAX)) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < SUMW'(OUT_MIN)) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic signed [SUMW-1:0] xs;
  logic signed [SUMW-1:0] rxs;
  logic signed [SUMW-1:0] rys;
  logic signed [SUMW-1:0] ycs;
  logic [PDW-1:0]         res;

  assign xs  = SUMW'($signed({1'b0, x_out}));
  assign rxs = SUMW'(rx_c);
  assign rys = SUMW'(ry_c);
  assign ycs = SUMW'(yc_d);

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= {sat_out(ycs), sat_out(ycs - rxs), sat_out(xs + rys),
              sat_out(ycs + rxs), sat_out(xs - rys)};
    end
  end

  // output queue
  logic [PDW-1:0] q_mem [2];
  logic           wp;
  logic           rp;
  logic           q_wr;
  logic           q_rd;

  assign q_wr     = vld[LAT-1] && adv;
  assign q_rd     = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {(96 - PDW)'(0), q_mem[rp]};

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_mem[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (q_wr) begin
        wp <= ~wp;
      end
      if (q_rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(q_wr) - 2'(q_rd);
    end
  end

endmodule

>>> src/naca_dly.sv
// ----------------------------------------------------------------------------
// naca_dly: enabled delay line
// Holds side data in step with the main pipeline; advances on en.
// ----------------------------------------------------------------------------
module naca_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < D; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[D-1];

endmodule

>>> src/naca_div.sv
// ----------------------------------------------------------------------------
// naca_div: pipelined restoring divider
// One quotient bit per stage, NW stages; divisor and sign travel along.
// ----------------------------------------------------------------------------
module naca_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg_in,
  output logic [NW-1:0] quo,
  output logic          neg_out
);

  logic [NW-1:0] n_r   [NW];
  logic [NW-1:0] q_r   [NW];
  logic [DW-1:0] r_r   [NW];
  logic [DW-1:0] d_r   [NW];
  logic          neg_r [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [NW-1:0] n_p;
    logic [NW-1:0] q_p;
    logic [NW-1:0] q_n;
    logic [DW-1:0] r_p;
    logic [DW-1:0] d_p;
    logic [DW-1:0] r_n;
    logic          neg_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (g == 0) begin : g_first
      assign n_p   = num;
      assign q_p   = '0;
      assign r_p   = '0;
      assign d_p   = den;
      assign neg_p = neg_in;
    end else begin : g_next
      assign n_p   = n_r[g-1];
      assign q_p   = q_r[g-1];
      assign r_p   = r_r[g-1];
      assign d_p   = d_r[g-1];
      assign neg_p = neg_r[g-1];
    end

    always_comb begin
      trial = {r_p, n_p[NW-1-g]};
      diff  = trial - {1'b0, d_p};
      q_n   = q_p;
      r_n   = trial[DW-1:0];
      if (trial >= {1'b0, d_p}) begin
        q_n[NW-1-g] = 1'b1;
        r_n         = diff[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[g]   <= n_p;
        q_r[g]   <= q_n;
        r_r[g]   <= r_n;
        d_r[g]   <= d_p;
        neg_r[g] <= neg_p;
      end
    end
  end

  assign quo     = q_r[NW-1];
  assign neg_out = neg_r[NW-1];

endmodule

>>> src/naca_sqrt.sv
// ----------------------------------------------------------------------------
// naca_sqrt: pipelined integer square root of (x << FB)
// One root bit per stage, most significant first; the square of the partial
// root travels along so each trial is an add and a compare.
// ----------------------------------------------------------------------------
module naca_sqrt #(
  parameter int XW = 17,
  parameter int FB = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [XW-1:0]           x,
  output logic [(XW+FB+1)/2-1:0]  root
);

  localparam int VW = XW + FB;
  localparam int RW = (XW + FB + 1) / 2;

  logic [RW-1:0] root_r [RW];
  logic [VW-1:0] sq_r   [RW];
  logic [VW-1:0] v_r    [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int B = RW - 1 - g;
    logic [RW-1:0] root_p;
    logic [RW-1:0] root_n;
    logic [VW-1:0] sq_p;
    logic [VW-1:0] sq_n;
    logic [VW-1:0] v_p;
    logic [VW+1:0] trial_sq;

    if (g == 0) begin : g_first
      assign root_p = '0;
      assign sq_p   = '0;
      assign v_p    = {x, {FB{1'b0}}};
    end else begin : g_next
      assign root_p = root_r[g-1];
      assign sq_p   = sq_r[g-1];
      assign v_p    = v_r[g-1];
    end

    // (root + 2^B)^2 = root^2 + root*2^(B+1) + 2^(2B)
    always_comb begin
      trial_sq = (VW+2)'(sq_p) + ((VW+2)'(root_p) << (B + 1)) + ((VW+2)'(1) << (2 * B));
      root_n   = root_p;
      sq_n     = sq_p;
      if (trial_sq <= (VW+2)'(v_p)) begin
        root_n[B] = 1'b1;
        sq_n      = trial_sq[VW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[g] <= root_n;
        sq_r[g]   <= sq_n;
        v_r[g]    <= v_p;
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

>>> src/naca_cordic.sv
// ----------------------------------------------------------------------------
// naca_cordic: paired vectoring and rotation CORDIC
// The vectoring half drives (ONE, slope) onto the x axis; the rotation half
// applies the opposite directions to (ytk, 0). One iteration per stage.
// ----------------------------------------------------------------------------
module naca_cordic #(
  parameter int CW = 21,
  parameter int FB = 16,
  parameter int CS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] slope,
  input  logic signed [CW-1:0] ytk,
  output logic signed [CW-1:0] rx,
  output logic signed [CW-1:0] ry
);

  logic signed [CW-1:0] vx_r [CS];
  logic signed [CW-1:0] vy_r [CS];
  logic signed [CW-1:0] rx_r [CS];
  logic signed [CW-1:0] ry_r [CS];

  for (genvar g = 0; g < CS; g++) begin : g_stage
    logic signed [CW-1:0] vx_p;
    logic signed [CW-1:0] vy_p;
    logic signed [CW-1:0] rx_p;
    logic signed [CW-1:0] ry_p;
    logic signed [CW-1:0] vx_n;
    logic signed [CW-1:0] vy_n;
    logic signed [CW-1:0] rx_n;
    logic signed [CW-1:0] ry_n;

    if (g == 0) begin : g_first
      assign vx_p = CW'(longint'(1) << FB);
      assign vy_p = slope;
      assign rx_p = ytk;
      assign ry_p = '0;
    end else begin : g_next
      assign vx_p = vx_r[g-1];
      assign vy_p = vy_r[g-1];
      assign rx_p = rx_r[g-1];
      assign ry_p = ry_r[g-1];
    end

    // hold once the vector lies on the axis
    always_comb begin
      vx_n = vx_p;
      vy_n = vy_p;
      rx_n = rx_p;
      ry_n = ry_p;
      if (vy_p > 0) begin
        vx_n = vx_p + (vy_p >>> g);
        vy_n = vy_p - (vx_p >>> g);
        rx_n = rx_p - (ry_p >>> g);
        ry_n = ry_p + (rx_p >>> g);
      end else if (vy_p < 0) begin
        vx_n = vx_p - (vy_p >>> g);
        vy_n = vy_p + (vx_p >>> g);
        rx_n = rx_p + (ry_p >>> g);
        ry_n = ry_p - (rx_p >>> g);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vx_r[g] <= vx_n;
        vy_r[g] <= vy_n;
        rx_r[g] <= rx_n;
        ry_r[g] <= ry_n;
      end
    end
  end

  assign rx = rx_r[CS-1];
  assign ry = ry_r[CS-1];

endmodule

>>> src/naca_chk.sv
// ----------------------------------------------------------------------------
// naca_chk: port-level checks for the airfoil point pipeline
// Reset, stall and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module naca_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);
  import naca_pkg::*;

  logic signed [OUT_W:0] y_sum;
  logic signed [OUT_W:0] y_two;

  assign y_sum = (OUT_W+1)'($signed(m_tdata[35:18])) + (OUT_W+1)'($signed(m_tdata[71:54]));
  assign y_two = (OUT_W+1)'($signed(m_tdata[89:72])) <<< 1;

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input stalls only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // surfaces sit symmetric about the camber line
  a_camber_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (y_sum == y_two) && (m_tdata[95:90] == 6'd0))
    else $error("upper and lower y not symmetric about camber");

endmodule

bind naca_four_digit_airfoil_point naca_chk u_naca_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> tb/naca_four_digit_airfoil_point_tb.sv
// ----------------------------------------------------------------------------
// naca_four_digit_airfoil_point_tb: self-checking bench for the airfoil point pipeline
// Streams chordwise positions under several digit settings. A scoreboard
// computes the expected surface points and camber height in fixed point.
// Each output item is checked field by field against the oldest expectation.
// Both stream sides idle at random. The output side also holds off for one
// long stretch, so that the output queue fills and the input stalls.
// ----------------------------------------------------------------------------
module naca_four_digit_airfoil_point_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import naca_pkg::*;

  localparam int  FRAC     = 16;
  localparam int  STAGES   = 16;
  localparam longint ONE   = 64'd1 << FRAC;
  localparam int  IDLE_LIM = 5000;
  localparam int  HOLD_LEN = 400;

  class airfoil_scoreboard;
    longint m_dig, p_dig, t_pct;
    logic [89:0] pending[$];
    int errors;

    function new();
      m_dig = 2; p_dig = 4; t_pct = 13; errors = 0;
    endfunction

    function void set_digit(cfg_idx_t idx, logic [5:0] val);
      case (idx)
        CFG_MAX_CAMBER: m_dig = val[3:0];
        CFG_CAMBER_POS: p_dig = val[3:0];
        CFG_THICKNESS:  t_pct = val;
        default: ;
      endcase
    endfunction

    function longint rdiv(longint n, longint d);
      longint q;
      q = ((n < 0 ? -n : n) + d / 2) / d;
      return n < 0 ? -q : q;
    endfunction

    function longint qmul(longint a, longint b);
      longint q;
      q = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (ONE / 2)) >>> FRAC;
      return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function logic [17:0] clip(longint v);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[17:0];
    endfunction

    function void note_position(logic [16:0] xr);
      longint m, p, t, x, x2, x3, x4, sq, poly, yt, yc, slope, den, s;
      longint vx, vy, rx, ry, nvx, nvy, nrx, nry, ytk, invk;
      logic [63:0] v, root, trial;
      bit fore;
      m = m_dig > 9 ? 9 : m_dig;
      p = p_dig > 9 ? 9 : p_dig;
      t = t_pct > 40 ? 40 : t_pct;
      x = xr > ONE ? ONE : xr;
      x2 = qmul(x, x);
      x3 = qmul(x2, x);
      x4 = qmul(x2, x2);
      v = x << FRAC;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      sq = root;
      poly = C_SQ * sq - C_X1 * x - C_X2 * x2 + C_X3 * x3 - C_X4 * x4;
      yt = rdiv(t * poly, YT_DEN);
      yc = 0;
      slope = 0;
      if (m != 0) begin
        fore = (p != 0) && (10 * x <= p * ONE);
        if (fore) begin
          den = p * p;
          s = 20 * p * x - 100 * x2;
        end else begin
          den = (10 - p) * (10 - p);
          s = 100 * ONE - 20 * p * ONE + 20 * p * x - 100 * x2;
        end
        yc = rdiv(m * s, 100 * den);
        slope = rdiv(m * (2 * p * ONE - 20 * x), 10 * den);
      end
      invk = (INVK_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      ytk = qmul(yt, invk);
      vx = ONE; vy = slope; rx = ytk; ry = 0;
      for (int i = 0; i < STAGES; i++) begin
        if (vy == 0) break;
        if (vy > 0) begin
          nvx = vx + (vy >>> i); nvy = vy - (vx >>> i);
          nrx = rx - (ry >>> i); nry = ry + (rx >>> i);
        end else begin
          nvx = vx - (vy >>> i); nvy = vy + (vx >>> i);
          nrx = rx + (ry >>> i); nry = ry - (rx >>> i);
        end
        vx = nvx; vy = nvy; rx = nrx; ry = nry;
      end
      pending.push_back({clip(yc), clip(yc - rx), clip(x + ry), clip(yc + rx), clip(x - ry)});
    endfunction

    function void check_point(logic [95:0] got);
      logic [89:0] want;
      string names[5] = '{"upper_x", "upper_y", "lower_x", "lower_y", "camber_height"};
      if (pending.size() == 0) begin
        $display("%0t: output item expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int f = 0; f < 5; f++)
        if (got[f*18 +: 18] !== want[f*18 +: 18]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[f],
                   $signed(want[f*18 +: 18]), $signed(got[f*18 +: 18]));
          errors++;
        end
      if (got[95:90] !== 6'd0) begin
        $display("%0t: pad expected 0 actual %h", $time, got[95:90]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = '0;
  logic [5:0]  cfg_wdata = '0;

  airfoil_scoreboard sb = new();
  bit hold_out = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  naca_four_digit_airfoil_point dut (.*);

  initial forever #5 clk = ~clk;

  // output side: random stall pattern, quiet stretches, one long hold-off
  initial begin
    int mode, run;
    mode = 0; run = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_point(m_tdata);
      if (hold_out) begin
        m_tready <= 0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_out = 0;
      end
      if (run == 0) begin
        mode = $urandom_range(0, 2);
        run = $urandom_range(5, 60);
      end
      run--;
      case (mode)
        0: m_tready <= 1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // count cycles without any accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_position(logic [16:0] x);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= {7'd0, x};
    do @(posedge clk); while (!s_tready);
    sb.note_position(x);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_digit(logic [1:0] idx, logic [5:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_digit(cfg_idx_t'(idx), val);
    cfg_we <= 0;
  endtask

  task automatic set_foil(logic [5:0] m, logic [5:0] p, logic [5:0] t);
    write_digit(CFG_MAX_CAMBER, m);
    write_digit(CFG_CAMBER_POS, p);
    write_digit(CFG_THICKNESS, t);
  endtask

  function automatic logic [16:0] pick_position(int p);
    case ($urandom_range(0, 9))
      0: return 17'($urandom_range(0, 17'h1FFFF));
      1: return 17'($urandom_range(0, 64));
      2: return 17'(p * 6554 + $urandom_range(0, 4) - 2);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int foils[8][3] = '{'{2, 4, 13}, '{0, 4, 12}, '{4, 0, 15}, '{9, 9, 40},
                        '{0, 0, 0}, '{15, 15, 63}, '{6, 1, 41}, '{1, 8, 24}};
    logic [16:0] edges[10] = '{17'd0, 17'd1, 17'd65536, 17'd65537, 17'h1FFFF,
                                17'd26214, 17'd26215, 17'd32768, 17'h0AAAA, 17'h15555};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset digits first, then a few edge cases under other foils
    foreach (edges[i]) send_position(edges[i]);
    drain();
    write_digit(2'd3, 6'h3F);
    set_foil(0, 4, 12);
    foreach (edges[i]) if (i < 5) send_position(edges[i]);
    drain();
    set_foil(9, 9, 40);
    foreach (edges[i]) if (i < 5) send_position(edges[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_foil(foils[ph][0], foils[ph][1], foils[ph][2]);
      for (int k = 0; k < 140; k++) begin
        if (ph == 2 && k == 20) hold_out = 1;
        if (ph == 5 && k == 70) drain();
        send_position(pick_position(foils[ph][1] > 9 ? 9 : foils[ph][1]));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
